// ===== rtl/core/crcp_pkg.sv =====
// Package for the configurable-polynomial CRC block.
// Item types, register indexes and default sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crcp_pkg;

    // Largest supported degree (default of the top-level parameter)
    localparam int MAX_DEGREE_DEF = 32;

    // Fixed field widths of the items and registers
    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 32;
    localparam int POLY_W  = 33;
    localparam int START_W = 32;
    localparam int CFG_W   = 33;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 2'd1;

    // Input item
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              restart;
        logic              end_of_message;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             is_final;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/crcp_fold.sv =====
// Byte fold of the CRC: eight MSB-first shift/XOR steps at a variable degree.
// Uses crcp_pkg for the input item type.
`timescale 1ns / 1ps
`default_nettype none

module crcp_fold #(
    parameter int MAX_DEGREE = crcp_pkg::MAX_DEGREE_DEF
) (
    input  wire logic [MAX_DEGREE:0]   i_poly,
    input  wire logic [MAX_DEGREE-1:0] i_start,
    input  wire logic [MAX_DEGREE-1:0] i_rem,
    input  wire crcp_pkg::t_in_item    i_item,
    output logic [MAX_DEGREE-1:0]      o_rem
);

    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] top;
    logic [MAX_DEGREE-1:0] poly_low;
    logic [MAX_DEGREE-1:0] acc;
    logic                  fb;

    // Mask of all bits below the highest set polynomial bit (degree n)
    for (genvar gi = 0; gi < MAX_DEGREE; gi++) begin : g_mask
        assign mask[gi] = |i_poly[MAX_DEGREE:gi+1];
    end

    // Bit n-1 selects the feedback; poly_low is P without its top term
    assign top      = mask ^ (mask >> 1);
    assign poly_low = i_poly[MAX_DEGREE-1:0] & mask;

    // Fold the byte in, most significant bit first; degree zero gives zero
    always_comb begin
        acc = i_item.restart ? (i_start & mask) : (i_rem & mask);
        fb  = 1'b0;
        for (int b = crcp_pkg::BYTE_W - 1; b >= 0; b--) begin
            fb  = (|(acc & top)) ^ i_item.data_byte[3'(b)];
            acc = ((acc << 1) & mask) ^ (fb ? poly_low : '0);
        end
        o_rem = acc;
    end

endmodule

`default_nettype wire

// ===== rtl/core/crc_configurable_poly.sv =====
// Top level of the byte-wise MSB-first CRC with a programmable polynomial.
// Uses crcp_pkg (types, register indexes) and crcp_fold (byte fold).
`timescale 1ns / 1ps
`default_nettype none

// Byte-wise CRC, most significant bit first, with a programmable generator.
// Register 0 holds the polynomial including its top bit; the degree n is the
// position of its highest set bit (bits above MAX_DEGREE are ignored), and a
// degree of zero gives a CRC of zero. Register 1 holds the start value, which
// an item with restart set loads (masked to n bits) before its byte is folded.
// Each item gives one result: the remainder after the byte, n bits wide, and
// an echo of end_of_message. One item is taken every cycle unless o_in_stall
// is high; an accepted item sits in the input register, and the eight-step
// byte fold moves it into the result register once that register is free,
// where its result stays valid until the receiver takes it.
// The result register lets the next item enter while a result waits. Write
// registers only while no item is in flight.
module crc_configurable_poly #(
    parameter int MAX_DEGREE = crcp_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [crcp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [crcp_pkg::CFG_W-1:0]       i_cfg_data,
    // input items
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire crcp_pkg::t_in_item               i_in_item,
    // result items
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output crcp_pkg::t_out_item                   o_out_item
);

    logic [crcp_pkg::POLY_W-1:0]  r_poly;
    logic [crcp_pkg::START_W-1:0] r_start;
    logic [MAX_DEGREE-1:0]        r_rem;
    logic                         r_in_valid;
    crcp_pkg::t_in_item           r_in_item;
    logic                         r_out_valid;
    crcp_pkg::t_out_item          r_out_item;
    logic [MAX_DEGREE-1:0]        n_rem;
    logic                         out_free;
    logic                         advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly  <= crcp_pkg::POLY_W'(263);
            r_start <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == crcp_pkg::CFG_POLYNOMIAL) begin
                r_poly <= i_cfg_data;
            end else if (i_cfg_idx == crcp_pkg::CFG_START_VALUE) begin
                r_start <= i_cfg_data[crcp_pkg::START_W-1:0];
            end
        end
    end

    // Handshake: the input stage moves when the result register is free
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Byte fold between the input register and the result register
    crcp_fold #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_fold (
        .i_poly  (r_poly[MAX_DEGREE:0]),
        .i_start (r_start[MAX_DEGREE-1:0]),
        .i_rem   (r_rem),
        .i_item  (r_in_item),
        .o_rem   (n_rem)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Running remainder and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_rem <= n_rem;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item.crc_value <= crcp_pkg::CRC_W'(n_rem);
            r_out_item.is_final  <= r_in_item.end_of_message;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    // A held input stage keeps its item while the result register is full
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input stage lost its item while stalled");

    // Every advanced item lands in the result register
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced item produced no result");

    // The stored remainder matches the CRC just delivered
    a_rem_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_rem == r_out_item.crc_value[MAX_DEGREE-1:0]))
        else $error("running remainder differs from result");

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("stages not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_crc_configurable_poly.sv =====
// Self-checking testbench for crc_configurable_poly: random byte messages
// under random polynomials and start values, checked against an internal CRC model.
// Depends on crcp_pkg (item types, register indexes) and the block itself.
`timescale 1ns / 1ps

module tb_crc_configurable_poly;

    localparam int WDOG_LIMIT  = 4000;  // cycles with no item moving on either side
    localparam int FLUSH_CYCLES = 4;    // two-stage pipe plus margin
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int RAND_PHASES = 13;
    localparam int PHASE_ITEMS = 100;

    // register indexes the block does not decode
    localparam logic [crcp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [crcp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [crcp_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [crcp_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    crcp_pkg::t_in_item             in_item = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    crcp_pkg::t_out_item            out_item;

    // model copy of the registers and the running remainder
    logic [crcp_pkg::POLY_W-1:0]  mdl_poly  = 33'd263;
    logic [crcp_pkg::START_W-1:0] mdl_start = '0;
    logic [crcp_pkg::CRC_W-1:0]   mdl_rem   = '0;

    crcp_pkg::t_in_item  byte_q[$];       // bytes waiting to be offered
    crcp_pkg::t_out_item crc_expect_q[$]; // predicted results, oldest first

    int  fail_cnt = 0;
    int  idle_cycles = 0;
    int  snd_gap = 0;
    int  rcv_gap = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    bit  quiet = 1'b0;

    crc_configurable_poly dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Fold one byte into the model remainder, MSB first, and return the result
    function automatic crcp_pkg::t_out_item fold_byte_crc(crcp_pkg::t_in_item it);
        logic [63:0]         p;
        logic [63:0]         mask;
        logic [63:0]         r;
        logic [63:0]         acc;
        int                  n;
        crcp_pkg::t_out_item res;
        p = {31'b0, mdl_poly};
        n = 0;
        for (int b = 1; b <= 32; b++) begin
            if (p[b]) n = b;
        end
        res.is_final = it.end_of_message;
        if (n == 0) begin
            // degree zero: everything reduces to nothing
            mdl_rem = '0;
            res.crc_value = '0;
            return res;
        end
        mask = (64'd1 << n) - 64'd1;
        r = it.restart ? ({32'b0, mdl_start} & mask) : ({32'b0, mdl_rem} & mask);
        acc = (r << 8) ^ ({56'b0, it.data_byte} << n);
        for (int i = n + 7; i >= n; i--) begin
            if (acc[i]) acc = acc ^ (p << (i - n));
        end
        acc = acc & mask;
        mdl_rem = acc[31:0];
        res.crc_value = acc[31:0];
        return res;
    endfunction

    // Random generator polynomial, extremes and low degrees included
    function automatic logic [crcp_pkg::POLY_W-1:0] pick_poly();
        logic [crcp_pkg::POLY_W-1:0] v;
        int                          d;
        d = $urandom_range(1, 32);
        v = crcp_pkg::POLY_W'({$urandom, $urandom});
        case ($urandom_range(0, 11))
            0: v = crcp_pkg::POLY_W'($urandom_range(0, 1));
            1: v = 33'h1_FFFF_FFFF;
            2: v = 33'h1_04C1_1DB7;
            3: v = crcp_pkg::POLY_W'($urandom_range(2, 3));
            default: begin
                v = v & ((33'd1 << d) - 33'd1);
                v[d] = 1'b1;
            end
        endcase
        return v;
    endfunction

    function automatic logic [crcp_pkg::CFG_W-1:0] pick_start();
        logic [crcp_pkg::CFG_W-1:0] v;
        v = crcp_pkg::CFG_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = 33'h1_FFFF_FFFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_byte(logic [7:0] b, logic rs, logic eom);
        crcp_pkg::t_in_item it;
        it.data_byte = b;
        it.restart = rs;
        it.end_of_message = eom;
        byte_q.push_back(it);
    endtask

    // Wait until every byte went in and every result came out
    task automatic wait_idle();
        while (byte_q.size() != 0 || in_valid || crc_expect_q.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    // Register write; the model follows at the same edge
    task automatic write_reg(logic [crcp_pkg::CFG_IDX_W-1:0] idx,
                             logic [crcp_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            crcp_pkg::CFG_POLYNOMIAL:  mdl_poly = val[crcp_pkg::POLY_W-1:0];
            crcp_pkg::CFG_START_VALUE: mdl_start = val[crcp_pkg::START_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly well-formed messages, some loose bytes with random flags
    task automatic send_messages(int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(1, 16);
                for (int k = 0; k < len; k++)
                    push_byte(8'($urandom), k == 0, k == len - 1);
            end else begin
                len = 1;
                push_byte(8'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            sent += len;
        end
        wait_idle();
    endtask

    // Sender: offers bytes from the queue, holds payload while stalled
    always @(posedge clk) begin : drv
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (snd_gap > 0 && !quiet) begin
                snd_gap--;
                in_valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                in_item <= byte_q.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) snd_gap = $urandom_range(1, 15);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    always @(posedge clk) begin : rcv
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (quiet) begin
            out_stall <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 11) == 0) begin
            rcv_gap = $urandom_range(1, 15) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: predict on input accept, compare on output accept
    always @(posedge clk) begin : mon
        crcp_pkg::t_out_item want;
        if (rst_n) begin
            if (in_valid && !in_stall)
                crc_expect_q.push_back(fold_byte_crc(in_item));
            if (out_valid && !out_stall) begin
                if (crc_expect_q.size() == 0) begin
                    $error("unexpected result: crc_value %h is_final %b",
                           out_item.crc_value, out_item.is_final);
                    fail_cnt++;
                end else begin
                    want = crc_expect_q.pop_front();
                    if (out_item.crc_value !== want.crc_value) begin
                        $error("crc_value: expected %h, actual %h",
                               want.crc_value, out_item.crc_value);
                        fail_cnt++;
                    end
                    if (out_item.is_final !== want.is_final) begin
                        $error("is_final: expected %b, actual %b",
                               want.is_final, out_item.is_final);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles where no item moves
    always @(posedge clk) begin : wdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: x^8+x^2+x+1, start zero
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hA5, 1'b0, 1'b1);
        wait_idle();

        // CRC-32 polynomial, all-ones start (bit 32 of the data is dropped)
        write_reg(crcp_pkg::CFG_POLYNOMIAL, 33'h1_04C1_1DB7);
        write_reg(crcp_pkg::CFG_START_VALUE, 33'h1_FFFF_FFFF);
        for (int k = 0; k < 9; k++)
            push_byte(8'(8'h31 + k), k == 0, k == 8);
        push_byte(8'h5A, 1'b0, 1'b0);
        push_byte(8'hC3, 1'b0, 1'b0);
        wait_idle();

        // polynomial shrinks mid-message: the stored remainder gets masked
        write_reg(crcp_pkg::CFG_POLYNOMIAL, 33'h107);
        push_byte(8'h81, 1'b0, 1'b0);
        push_byte(8'h7E, 1'b0, 1'b1);
        wait_idle();

        // every coefficient set
        write_reg(crcp_pkg::CFG_POLYNOMIAL, 33'h1_FFFF_FFFF);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        wait_idle();

        // degree zero, both forms
        write_reg(crcp_pkg::CFG_POLYNOMIAL, 33'h1);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h3C, 1'b0, 1'b1);
        wait_idle();
        write_reg(crcp_pkg::CFG_POLYNOMIAL, 33'h0);
        push_byte(8'h96, 1'b1, 1'b1);
        wait_idle();

        // degrees below eight
        write_reg(crcp_pkg::CFG_POLYNOMIAL, 33'h3);
        write_reg(crcp_pkg::CFG_START_VALUE, 33'h1);
        push_byte(8'hB7, 1'b1, 1'b0);
        push_byte(8'h48, 1'b0, 1'b1);
        wait_idle();
        write_reg(crcp_pkg::CFG_POLYNOMIAL, 33'h13);
        push_byte(8'hE1, 1'b1, 1'b0);
        push_byte(8'h1E, 1'b0, 1'b1);
        wait_idle();

        // undecoded indexes leave both registers alone
        write_reg(CFG_SPARE_A, 33'h0_0000_0002);
        write_reg(CFG_SPARE_B, 33'h1_DEAD_BEEF);
        push_byte(8'h6D, 1'b1, 1'b1);
        wait_idle();

        // random phases: a fresh polynomial each time and usually a fresh start value, long hold-off in one,
        // no idling in the last two
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 3) hold_req = 1'b1;
            if (ph == RAND_PHASES - 2) quiet = 1'b1;
            write_reg(crcp_pkg::CFG_POLYNOMIAL, pick_poly());
            if ($urandom_range(0, 3) != 0)
                write_reg(crcp_pkg::CFG_START_VALUE, pick_start());
            send_messages(PHASE_ITEMS);
        end

        wait_idle();
        if (crc_expect_q.size() != 0) begin
            $error("%0d results never arrived", crc_expect_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== crc_configurable_poly.f =====
rtl/core/crcp_pkg.sv
rtl/core/crcp_fold.sv
rtl/core/crc_configurable_poly.sv
verif/tb_crc_configurable_poly.sv
